>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/hpid_pkg.sv
package hpid_pkg;

    localparam int ANG_PI      = 25736;
    localparam int ANG_HALF_PI = 12868;
    localparam int ANG_TWO_PI  = 51472;
    localparam int CORDIC_N    = 14;

    localparam logic [2:0] CFG_P_GAIN      = 3'd0;
    localparam logic [2:0] CFG_I_GAIN      = 3'd1;
    localparam logic [2:0] CFG_D_GAIN      = 3'd2;
    localparam logic [2:0] CFG_GOAL_WEIGHT = 3'd3;
    localparam logic [2:0] CFG_LEAK_FACTOR = 3'd4;

    localparam logic [23:0] RST_P_GAIN      = 24'd3277;
    localparam logic [23:0] RST_I_GAIN      = 24'd109;
    localparam logic [23:0] RST_D_GAIN      = 24'd983040;
    localparam logic [16:0] RST_GOAL_WEIGHT = 17'd58982;
    localparam logic [16:0] RST_LEAK_FACTOR = 17'd55706;

    typedef struct packed {
        logic               cmd;
        logic signed [23:0] car_x;
        logic signed [23:0] car_y;
        logic signed [15:0] car_heading;
        logic signed [23:0] goal_x;
        logic signed [23:0] goal_y;
        logic signed [15:0] goal_heading;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] steer_command;
        logic signed [15:0] heading_error;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_BEAR, S_MWB, S_MGH, S_MIX, S_ERR,
        S_MP, S_MI, S_MD, S_MLK, S_UPD, S_CLR
    } t_state;

    typedef enum logic [1:0] {
        C_IDLE, C_NORM, C_ROT, C_DONE
    } t_cor_state;

    // arctangent of 2^-i in Q3.13
    function automatic logic [12:0] atan_lut(input logic [3:0] idx);
        logic [12:0] v;
        unique case (idx)
            4'd0:    v = 13'd6434;
            4'd1:    v = 13'd3798;
            4'd2:    v = 13'd2007;
            4'd3:    v = 13'd1019;
            4'd4:    v = 13'd511;
            4'd5:    v = 13'd256;
            4'd6:    v = 13'd128;
            4'd7:    v = 13'd64;
            4'd8:    v = 13'd32;
            4'd9:    v = 13'd16;
            4'd10:   v = 13'd8;
            4'd11:   v = 13'd4;
            4'd12:   v = 13'd2;
            4'd13:   v = 13'd1;
            default: v = 13'd0;
        endcase
        return v;
    endfunction

    // Q1.16 weights above one act as one
    function automatic logic [16:0] clamp_unit(input logic [16:0] v);
        return (v[16] && (v[15:0] != 16'd0)) ? 17'h10000 : v;
    endfunction

endpackage

>>> sv/hpid_mul.sv
module hpid_mul (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [24:0] i_a,
    input  logic signed [24:0] i_b,
    output logic signed [49:0] o_p
);

    logic signed [49:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

>>> sv/hpid_cordic.sv
module hpid_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [24:0] i_dx,
    input  logic signed [24:0] i_dy,
    output logic               o_done,
    output logic signed [15:0] o_bearing
);

    hpid_pkg::t_cor_state r_state, n_state;

    logic signed [34:0] r_x, r_y;
    logic signed [16:0] r_z;
    logic [3:0]         r_i;
    logic               r_dx_neg, r_dy_neg, r_dx_zero, r_dy_zero;

    logic [24:0]        abs_dx, abs_dy;
    logic signed [34:0] xs, ys;
    logic signed [16:0] step_ang;
    logic               norm_done;
    logic signed [15:0] a_sat;

    assign abs_dx    = i_dx[24] ? 25'(-i_dx) : i_dx;
    assign abs_dy    = i_dy[24] ? 25'(-i_dy) : i_dy;
    assign xs        = r_x >>> r_i;
    assign ys        = r_y >>> r_i;
    assign step_ang  = signed'({4'd0, hpid_pkg::atan_lut(r_i)});
    assign norm_done = ((r_x[34:30] | r_y[34:30]) != 5'd0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hpid_pkg::C_IDLE: begin
                if (i_start) begin
                    n_state = ((i_dx == 25'sd0) || (i_dy == 25'sd0)) ?
                              hpid_pkg::C_DONE : hpid_pkg::C_NORM;
                end
            end
            hpid_pkg::C_NORM: begin
                if (norm_done) begin
                    n_state = hpid_pkg::C_ROT;
                end
            end
            hpid_pkg::C_ROT: begin
                if (r_i == 4'(hpid_pkg::CORDIC_N - 1)) begin
                    n_state = hpid_pkg::C_DONE;
                end
            end
            hpid_pkg::C_DONE: n_state = hpid_pkg::C_IDLE;
            default:          n_state = hpid_pkg::C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hpid_pkg::C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            hpid_pkg::C_IDLE: begin
                if (i_start) begin
                    r_x       <= 35'(signed'({1'b0, abs_dx}));
                    r_y       <= 35'(signed'({1'b0, abs_dy}));
                    r_dx_neg  <= i_dx[24];
                    r_dy_neg  <= i_dy[24];
                    r_dx_zero <= (i_dx == 25'sd0);
                    r_dy_zero <= (i_dy == 25'sd0);
                    r_z       <= 17'sd0;
                    r_i       <= 4'd0;
                end
            end
            hpid_pkg::C_NORM: begin
                if (!norm_done) begin
                    r_x <= r_x <<< 1;
                    r_y <= r_y <<< 1;
                end
            end
            hpid_pkg::C_ROT: begin
                if (r_y > 35'sd0) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + step_ang;
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - step_ang;
                end
                r_i <= r_i + 4'd1;
            end
            default: begin
            end
        endcase
    end

    // first-quadrant angle clamped to [0, pi/2]
    assign a_sat = r_z[16] ? 16'sd0 :
                   (r_z > 17'(hpid_pkg::ANG_HALF_PI)) ? 16'(hpid_pkg::ANG_HALF_PI) :
                   r_z[15:0];

    always_comb begin
        priority if (r_dy_zero) begin
            o_bearing = 16'sd0;
        end else if (r_dx_zero) begin
            o_bearing = r_dy_neg ? -16'(hpid_pkg::ANG_HALF_PI) : 16'(hpid_pkg::ANG_HALF_PI);
        end else if (!r_dx_neg) begin
            o_bearing = r_dy_neg ? -a_sat : a_sat;
        end else begin
            o_bearing = r_dy_neg ? (a_sat - 16'(hpid_pkg::ANG_PI))
                                 : (16'(hpid_pkg::ANG_PI) - a_sat);
        end
    end

    assign o_done = (r_state == hpid_pkg::C_DONE);

endmodule

>>> sv/heading_pid_controller.sv
// Steps: the CORDIC goes straight to done when dx or dy is zero, otherwise it runs
// normalisation and 14 rotations; the result then takes six passes through one shared
// 25x25 multiplier. A clear command skips all of these.
// Throughput: one item at a time; the next is taken the cycle after the result is
// registered.
// Reset: synchronous, active low; gains return to defaults, history is zeroed.
`include "assert_macros.svh"

module heading_pid_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  hpid_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output hpid_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [23:0]          i_cfg_data
);

    hpid_pkg::t_state    r_state, n_state;
    hpid_pkg::t_in_item  r_item;
    hpid_pkg::t_out_item r_out;
    logic                r_out_valid;

    logic [23:0]         r_p_gain, r_i_gain, r_d_gain;
    logic [16:0]         r_goal_weight, r_leak_factor;
    logic signed [15:0]  r_bear, r_err, r_last;
    logic signed [23:0]  r_sum;
    logic signed [51:0]  r_acc;
    logic signed [17:0]  r_mix;

    logic                in_xfer, out_free, cor_start, cor_done, mul_en;
    logic signed [15:0]  cor_bearing;
    logic signed [24:0]  dx, dy, mul_a, mul_b;
    logic signed [49:0]  prod;
    logic signed [51:0]  prod_ext, mix_sum, st_sum, st_sh;
    logic signed [18:0]  diff, diff_mod;
    logic signed [15:0]  err_wrap;
    logic [16:0]         w_cl, lk_cl;
    logic signed [49:0]  lk_sum, lk_sh;
    logic signed [25:0]  ns;
    logic signed [23:0]  ns_sat;
    logic signed [31:0]  steer;
    logic                bear_wait, out_err_ok, clr_xfer, hist_zero;

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != hpid_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign w_cl  = hpid_pkg::clamp_unit(r_goal_weight);
    assign lk_cl = hpid_pkg::clamp_unit(r_leak_factor);
    assign dx    = 25'(r_item.goal_x) - 25'(r_item.car_x);
    assign dy    = 25'(r_item.goal_y) - 25'(r_item.car_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_gain      <= hpid_pkg::RST_P_GAIN;
            r_i_gain      <= hpid_pkg::RST_I_GAIN;
            r_d_gain      <= hpid_pkg::RST_D_GAIN;
            r_goal_weight <= hpid_pkg::RST_GOAL_WEIGHT;
            r_leak_factor <= hpid_pkg::RST_LEAK_FACTOR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                hpid_pkg::CFG_P_GAIN:      r_p_gain      <= i_cfg_data;
                hpid_pkg::CFG_I_GAIN:      r_i_gain      <= i_cfg_data;
                hpid_pkg::CFG_D_GAIN:      r_d_gain      <= i_cfg_data;
                hpid_pkg::CFG_GOAL_WEIGHT: r_goal_weight <= i_cfg_data[16:0];
                hpid_pkg::CFG_LEAK_FACTOR: r_leak_factor <= i_cfg_data[16:0];
                default: begin
                end
            endcase
        end
    end

    hpid_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (cor_start),
        .i_dx      (dx),
        .i_dy      (dy),
        .o_done    (cor_done),
        .o_bearing (cor_bearing)
    );

    hpid_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hpid_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = i_in_data.cmd ? hpid_pkg::S_CLR : hpid_pkg::S_DIFF;
                end
            end
            hpid_pkg::S_DIFF: n_state = hpid_pkg::S_BEAR;
            hpid_pkg::S_BEAR: begin
                if (cor_done) begin
                    n_state = hpid_pkg::S_MWB;
                end
            end
            hpid_pkg::S_MWB:  n_state = hpid_pkg::S_MGH;
            hpid_pkg::S_MGH:  n_state = hpid_pkg::S_MIX;
            hpid_pkg::S_MIX:  n_state = hpid_pkg::S_ERR;
            hpid_pkg::S_ERR:  n_state = hpid_pkg::S_MP;
            hpid_pkg::S_MP:   n_state = hpid_pkg::S_MI;
            hpid_pkg::S_MI:   n_state = hpid_pkg::S_MD;
            hpid_pkg::S_MD:   n_state = hpid_pkg::S_MLK;
            hpid_pkg::S_MLK:  n_state = hpid_pkg::S_UPD;
            hpid_pkg::S_UPD, hpid_pkg::S_CLR: begin
                if (out_free) begin
                    n_state = hpid_pkg::S_IDLE;
                end
            end
            default: n_state = hpid_pkg::S_IDLE;
        endcase
    end

    // multiplier operand select and CORDIC start
    always_comb begin
        cor_start = 1'b0;
        mul_en    = 1'b0;
        mul_a     = 25'sd0;
        mul_b     = 25'sd0;
        unique case (r_state)
            hpid_pkg::S_DIFF: cor_start = 1'b1;
            hpid_pkg::S_MWB: begin
                mul_en = 1'b1;
                mul_a  = signed'({8'd0, w_cl});
                mul_b  = 25'(r_bear);
            end
            hpid_pkg::S_MGH: begin
                mul_en = 1'b1;
                mul_a  = signed'({8'd0, 17'h10000 - w_cl});
                mul_b  = 25'(r_item.goal_heading);
            end
            hpid_pkg::S_MP: begin
                mul_en = 1'b1;
                mul_a  = signed'({1'b0, r_p_gain});
                mul_b  = 25'(r_err);
            end
            hpid_pkg::S_MI: begin
                mul_en = 1'b1;
                mul_a  = signed'({1'b0, r_i_gain});
                mul_b  = 25'(r_sum);
            end
            hpid_pkg::S_MD: begin
                mul_en = 1'b1;
                mul_a  = signed'({1'b0, r_d_gain});
                mul_b  = 25'(r_err) - 25'(r_last);
            end
            hpid_pkg::S_MLK: begin
                mul_en = 1'b1;
                mul_a  = signed'({8'd0, lk_cl});
                mul_b  = 25'(r_sum);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hpid_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign prod_ext = 52'(prod);
    assign mix_sum  = r_acc + prod_ext + 52'sd32768;

    assign diff = 19'(r_mix) - 19'(r_item.car_heading);

    // truncating remainder by 2*pi; |diff| stays below twice the modulus
    always_comb begin
        priority if (diff >= 19'(hpid_pkg::ANG_TWO_PI)) begin
            diff_mod = diff - 19'(hpid_pkg::ANG_TWO_PI);
        end else if (diff <= -19'(hpid_pkg::ANG_TWO_PI)) begin
            diff_mod = diff + 19'(hpid_pkg::ANG_TWO_PI);
        end else begin
            diff_mod = diff;
        end
    end

    always_comb begin
        priority if (diff_mod > 19'(hpid_pkg::ANG_PI)) begin
            err_wrap = 16'(diff_mod - 19'(hpid_pkg::ANG_TWO_PI));
        end else if (diff_mod < -19'(hpid_pkg::ANG_PI)) begin
            err_wrap = 16'(diff_mod + 19'(hpid_pkg::ANG_TWO_PI));
        end else begin
            err_wrap = 16'(diff_mod);
        end
    end

    assign st_sum = r_acc + 52'sd4096;
    assign st_sh  = st_sum >>> 13;
    assign steer  = (st_sh > 52'sd2147483647)  ? 32'sh7fffffff :
                    (st_sh < -52'sd2147483648) ? 32'sh80000000 : st_sh[31:0];

    assign lk_sum = prod + 50'sd32768;
    assign lk_sh  = lk_sum >>> 16;
    assign ns     = 26'(lk_sh) + 26'(r_err);
    assign ns_sat = (ns > 26'sd8388607)  ? 24'sh7fffff :
                    (ns < -26'sd8388608) ? 24'sh800000 : ns[23:0];

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            hpid_pkg::S_IDLE: begin
                if (in_xfer) begin
                    r_item <= i_in_data;
                end
            end
            hpid_pkg::S_BEAR: begin
                if (cor_done) begin
                    r_bear <= cor_bearing;
                end
            end
            hpid_pkg::S_MGH: r_acc <= prod_ext;
            hpid_pkg::S_MIX: r_mix <= mix_sum[33:16];
            hpid_pkg::S_ERR: r_err <= err_wrap;
            hpid_pkg::S_MI:  r_acc <= prod_ext;
            hpid_pkg::S_MD:  r_acc <= r_acc + prod_ext;
            hpid_pkg::S_MLK: r_acc <= r_acc + prod_ext;
            hpid_pkg::S_UPD: begin
                if (out_free) begin
                    r_out.steer_command <= steer;
                    r_out.heading_error <= r_err;
                end
            end
            hpid_pkg::S_CLR: begin
                if (out_free) begin
                    r_out.steer_command <= 32'sd0;
                    r_out.heading_error <= 16'sd0;
                end
            end
            default: begin
            end
        endcase
    end

    // error history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= 24'sd0;
            r_last <= 16'sd0;
        end else if (out_free && (r_state == hpid_pkg::S_UPD)) begin
            r_sum  <= ns_sat;
            r_last <= r_err;
        end else if (out_free && (r_state == hpid_pkg::S_CLR)) begin
            r_sum  <= 24'sd0;
            r_last <= 16'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free &&
                     ((r_state == hpid_pkg::S_UPD) || (r_state == hpid_pkg::S_CLR))) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign bear_wait  = (r_state == hpid_pkg::S_BEAR);
    assign out_err_ok = (r_out.heading_error <= 16'(hpid_pkg::ANG_PI)) &&
                        (r_out.heading_error >= -16'(hpid_pkg::ANG_PI));
    assign clr_xfer   = (r_state == hpid_pkg::S_CLR) && out_free;
    assign hist_zero  = (r_sum == 24'sd0) && (r_last == 16'sd0);

    `ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, in_xfer, o_in_stall)
    `ASSERT_ALWAYS(a_cordic_done_in_bear, i_clk, i_rst_n, !cor_done || bear_wait)
    `ASSERT_ALWAYS(a_err_range, i_clk, i_rst_n, !r_out_valid || out_err_ok)
    `ASSERT_NEXT(a_clear_history, i_clk, i_rst_n, clr_xfer, hist_zero)

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_CYCLES   = 70;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          ITEMS_PER_SET  = 330;
    localparam logic [2:0]  CFG_UNUSED     = 3'd7;
    localparam logic        CMD_STEP       = 1'b0;
    localparam logic        CMD_CLEAR      = 1'b1;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    hpid_pkg::t_in_item   i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    hpid_pkg::t_out_item  o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [2:0]           i_cfg_index;
    logic [23:0]          i_cfg_data;

    int mismatches;
    int n_steps;
    int n_clears;
    int n_results;
    int idle_cycles;
    bit hold_request;

    heading_pid_controller dut (.*);

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    class steer_scoreboard;
        hpid_pkg::t_out_item expected_q[$];
        longint    p_gain, i_gain, d_gain, goal_weight, leak_factor;
        longint    last_err, err_sum;

        function void reset_state();
            p_gain      = hpid_pkg::RST_P_GAIN;
            i_gain      = hpid_pkg::RST_I_GAIN;
            d_gain      = hpid_pkg::RST_D_GAIN;
            goal_weight = hpid_pkg::RST_GOAL_WEIGHT;
            leak_factor = hpid_pkg::RST_LEAK_FACTOR;
            last_err    = 0;
            err_sum     = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [23:0] val);
            case (idx)
                hpid_pkg::CFG_P_GAIN:      p_gain = val;
                hpid_pkg::CFG_I_GAIN:      i_gain = val;
                hpid_pkg::CFG_D_GAIN:      d_gain = val;
                hpid_pkg::CFG_GOAL_WEIGHT: goal_weight = val[16:0];
                hpid_pkg::CFG_LEAK_FACTOR: leak_factor = val[16:0];
                default: ;
            endcase
        endfunction

        function longint arctan_q1(longint ax, longint ay);
            longint tab [hpid_pkg::CORDIC_N] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64,
                                                 32, 16, 8, 4, 2, 1};
            longint m, x, y, z, xs, ys;
            m = (ax > ay) ? ax : ay;
            while (m < (64'sd1 <<< 30)) begin
                ax = ax <<< 1;
                ay = ay <<< 1;
                m  = m <<< 1;
            end
            x = ax;
            y = ay;
            z = 0;
            for (int i = 0; i < hpid_pkg::CORDIC_N; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x += ys; y -= xs; z += tab[i];
                end else begin
                    x -= ys; y += xs; z -= tab[i];
                end
            end
            if (z < 0) z = 0;
            if (z > hpid_pkg::ANG_HALF_PI) z = hpid_pkg::ANG_HALF_PI;
            return z;
        endfunction

        function longint bearing_to_goal(longint dx, longint dy);
            longint a;
            if (dy == 0) return 0;
            if (dx == 0) return (dy > 0) ? hpid_pkg::ANG_HALF_PI : -hpid_pkg::ANG_HALF_PI;
            a = arctan_q1(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
            if (dx > 0) return (dy > 0) ? a : -a;
            return (dy > 0) ? hpid_pkg::ANG_PI - a : a - hpid_pkg::ANG_PI;
        endfunction

        function void note_input(hpid_pkg::t_in_item it);
            longint    dx, dy, b, w, lk, mix, err, acc, steer, ns;
            hpid_pkg::t_out_item res;
            if (it.cmd == CMD_CLEAR) begin
                last_err = 0;
                err_sum  = 0;
                res      = '0;
                expected_q.push_back(res);
                return;
            end
            dx  = longint'(it.goal_x) - longint'(it.car_x);
            dy  = longint'(it.goal_y) - longint'(it.car_y);
            b   = bearing_to_goal(dx, dy);
            w   = (goal_weight > 65536) ? 65536 : goal_weight;
            mix = (w * b + (65536 - w) * longint'(it.goal_heading) + 32768) >>> 16;
            err = (mix - longint'(it.car_heading)) % hpid_pkg::ANG_TWO_PI;
            if (err > hpid_pkg::ANG_PI) err -= hpid_pkg::ANG_TWO_PI;
            else if (err < -hpid_pkg::ANG_PI) err += hpid_pkg::ANG_TWO_PI;
            acc   = p_gain * err + i_gain * err_sum + d_gain * (err - last_err);
            steer = (acc + 4096) >>> 13;
            if (steer > 64'sd2147483647) steer = 64'sd2147483647;
            if (steer < -64'sd2147483648) steer = -64'sd2147483648;
            lk = (leak_factor > 65536) ? 65536 : leak_factor;
            ns = ((lk * err_sum + 32768) >>> 16) + err;
            if (ns > 8388607) ns = 8388607;
            if (ns < -8388608) ns = -8388608;
            err_sum  = ns;
            last_err = err;
            res.steer_command = steer[31:0];
            res.heading_error = err[15:0];
            expected_q.push_back(res);
        endfunction

        task check_result(hpid_pkg::t_out_item got);
            hpid_pkg::t_out_item want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result steer", got.steer_command, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.steer_command !== want.steer_command)
                report_mismatch("steer_command", got.steer_command, want.steer_command);
            if (got.heading_error !== want.heading_error)
                report_mismatch("heading_error", got.heading_error, want.heading_error);
        endtask
    endclass

    steer_scoreboard sb = new();

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        hold_request = 1'b0;
        sb.reset_state();
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog: cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: checks results, stalls on a slowly changing pattern and holds off once on request
    initial begin : receiver
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_out_data);
                n_results++;
            end
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                left = 0;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 300);
            end
            left--;
            case (mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 1) == 0);
                default: i_out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic write_cfg(input logic [2:0] idx, input logic [23:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic send_item(input hpid_pkg::t_in_item it, input int gap);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
        if (it.cmd == CMD_CLEAR) n_clears++;
        else n_steps++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic hpid_pkg::t_in_item make_step(int cx, int cy, int ch,
                                                     int gx, int gy, int gh);
        hpid_pkg::t_in_item it;
        it.cmd = CMD_STEP;
        it.car_x = 24'(cx); it.car_y = 24'(cy); it.car_heading = 16'(ch);
        it.goal_x = 24'(gx); it.goal_y = 24'(gy); it.goal_heading = 16'(gh);
        return it;
    endfunction

    function automatic logic [15:0] rand_heading();
        if ($urandom_range(0, 9) == 0) return 16'($urandom());
        return 16'($urandom_range(0, 2 * hpid_pkg::ANG_PI)) - 16'(hpid_pkg::ANG_PI);
    endfunction

    function automatic hpid_pkg::t_in_item rand_item();
        hpid_pkg::t_in_item it;
        it.cmd = ($urandom_range(0, 39) == 0) ? CMD_CLEAR : CMD_STEP;
        it.car_x = 24'($urandom());
        it.car_y = 24'($urandom());
        it.goal_x = 24'($urandom());
        it.goal_y = 24'($urandom());
        case ($urandom_range(0, 5))
            0: begin   // short distances
                it.goal_x = it.car_x + 24'($signed(5'($urandom())));
                it.goal_y = it.car_y + 24'($signed(5'($urandom())));
            end
            1: it.goal_x = it.car_x;
            2: it.goal_y = it.car_y;
            default: ;
        endcase
        it.car_heading  = rand_heading();
        it.goal_heading = rand_heading();
        return it;
    endfunction

    task automatic run_directed();
        hpid_pkg::t_in_item c;
        send_item(make_step(0, 0, 0, 100, 0, 0), 0);
        send_item(make_step(0, 0, 0, -100, 0, hpid_pkg::ANG_PI), 1);
        send_item(make_step(5, 5, 0, 5, 900, 0), 0);
        send_item(make_step(5, 5, 100, 5, -900, 0), 0);
        send_item(make_step(7, -7, -hpid_pkg::ANG_PI, 7, -7, hpid_pkg::ANG_PI), 2);
        send_item(make_step(-8388608, -8388608, hpid_pkg::ANG_PI,
                            8388607, 8388607, -hpid_pkg::ANG_PI), 0);
        send_item(make_step(8388607, 8388607, -hpid_pkg::ANG_PI,
                            -8388608, -8388608, hpid_pkg::ANG_PI), 0);
        send_item(make_step(8388607, -8388608, 0, -8388608, 8388607, 0), 0);
        send_item(make_step(-8388608, 8388607, 0, 8388607, -8388608, 0), 0);
        send_item(make_step(0, 0, -32768, 3, 4, 32767), 0);
        send_item(make_step(0, 0, 32767, -3, -4, -32768), 3);
        send_item(make_step(0, 0, 0, 1, 1, 0), 0);
        send_item(make_step(0, 0, 0, -1, 1, 0), 0);
        send_item(make_step(0, 0, 0, -1, -1, 0), 0);
        send_item(make_step(0, 0, 0, 1, -1, 0), 0);
        send_item(make_step(0, 0, 0, 8388607, 1, 0), 0);
        send_item(make_step(0, 0, 0, 1, 8388607, 0), 0);
        c = '0;
        c.cmd = CMD_CLEAR;
        send_item(c, 0);
        c = '1;
        send_item(c, 0);
        send_item(make_step(0, 0, 1000, 0, 0, -1000), 0);
    endtask

    task automatic run_random(input int count);
        int burst;
        int gap;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) burst = $urandom_range(1, 20);
            burst--;
            gap = (burst == 0) ? $urandom_range(1, 15) : 0;
            send_item(rand_item(), gap);
        end
    endtask

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        hold_request = 1'b1;
        run_random(ITEMS_PER_SET);
        wait_idle();

        // all gains and weights at zero, plus a write to an unused index
        write_cfg(hpid_pkg::CFG_P_GAIN, 24'd0);
        write_cfg(hpid_pkg::CFG_I_GAIN, 24'd0);
        write_cfg(hpid_pkg::CFG_D_GAIN, 24'd0);
        write_cfg(hpid_pkg::CFG_GOAL_WEIGHT, 24'd0);
        write_cfg(hpid_pkg::CFG_LEAK_FACTOR, 24'd0);
        write_cfg(CFG_UNUSED, 24'hFFFFFF);
        run_random(ITEMS_PER_SET);
        wait_idle();

        // everything at the top: saturation and oversized weights
        write_cfg(hpid_pkg::CFG_P_GAIN, 24'hFFFFFF);
        write_cfg(hpid_pkg::CFG_I_GAIN, 24'hFFFFFF);
        write_cfg(hpid_pkg::CFG_D_GAIN, 24'hFFFFFF);
        write_cfg(hpid_pkg::CFG_GOAL_WEIGHT, 24'h1FFFF);
        write_cfg(hpid_pkg::CFG_LEAK_FACTOR, 24'h1FFFF);
        run_random(ITEMS_PER_SET);
        wait_idle();

        // unity weights, full leak, modest gains, plus a write to an unused index
        write_cfg(hpid_pkg::CFG_P_GAIN, 24'h010000);
        write_cfg(hpid_pkg::CFG_I_GAIN, 24'h000400);
        write_cfg(hpid_pkg::CFG_D_GAIN, 24'h008000);
        write_cfg(hpid_pkg::CFG_GOAL_WEIGHT, 24'h010000);
        write_cfg(hpid_pkg::CFG_LEAK_FACTOR, 24'h010000);
        write_cfg(CFG_UNUSED - 3'd2, 24'h123456);
        run_random(ITEMS_PER_SET);
        wait_idle();

        for (int k = 0; k < 2; k++) begin
            write_cfg(hpid_pkg::CFG_P_GAIN, 24'($urandom()));
            write_cfg(hpid_pkg::CFG_I_GAIN, 24'($urandom()));
            write_cfg(hpid_pkg::CFG_D_GAIN, 24'($urandom()));
            write_cfg(hpid_pkg::CFG_GOAL_WEIGHT, 24'($urandom_range(0, 65536)));
            write_cfg(hpid_pkg::CFG_LEAK_FACTOR, 24'($urandom_range(0, 65536)));
            run_random(ITEMS_PER_SET);
            wait_idle();
        end

        i_in_valid <= 1'b0;
        $display("covered %0d control steps and %0d clears over six gain settings,",
                 n_steps, n_clears);
        $display("%0d results checked, including a long output hold-off", n_results);
        if (mismatches == 0 && sb.expected_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
